[hdl/sst_pkg.sv]
package sst_pkg;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_ENTER  = 2'd2,
      ACT_LEAVE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_REDECL    = 3'd1,
      ST_UNDECL    = 3'd2,
      ST_FULL      = 3'd3,
      ST_DEEP      = 3'd4,
      ST_UNDERFLOW = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_LEAVE_WAIT,
      FSM_EMIT
   } state_type;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS_STEP = 2'd1;

   localparam logic [31:0] BASE_ADDRESS_RESET = 32'd1000;
   localparam logic [15:0] ADDRESS_STEP_RESET = 16'd4;

   typedef struct packed {
      action_type  action;
      logic [15:0] name_id;
      logic [7:0]  type_code;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  found_type;
      logic [31:0] found_address;
      logic [3:0]  found_scope;
      logic [3:0]  level_now;
   } rsp_type;

   typedef struct packed {
      logic [15:0] name_id;
      logic [7:0]  type_code;
      logic [31:0] address;
      logic [3:0]  scope;
   } sym_entry_type;

endpackage

[hdl/scoped_symbol_table.sv]
// Block-scoped symbol table. Each request inserts a symbol, looks one up,
// enters a scope or leaves one, and returns exactly one response. Insert and
// lookup walk the stored entries newest first through one name comparator fed
// by the entry memory's single read port, one entry per cycle; insert searches
// only the current scope, lookup all scopes. A leave that succeeds passes
// through FSM_LEAVE_WAIT for the scope-stack memory read. The block takes one
// request at a time; a finished response waits in the output register, and
// the next request is accepted while it waits. Write configuration only while
// no request is in flight; writing base_address also restarts the address
// counter.
module scoped_symbol_table #(
   parameter int MAX_ENTRIES = 64,
   parameter int MAX_LEVELS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  sst_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output sst_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [sst_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [31:0]                          csr_wdata
);

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int LW = $clog2(MAX_LEVELS);
   localparam int EW = $bits(sst_pkg::sym_entry_type);

   sst_pkg::state_type state_ff, state_in;
   logic [LW-1:0]      level_ff, level_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      cur_start_ff, cur_start_in;
   logic [CW-1:0]      lo_ff, lo_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic               pend_ff, pend_in;
   logic               last_ff, last_in;
   logic               empty_ff, empty_in;
   logic [15:0]        step_ff, step_in;
   logic [31:0]        next_addr_ff, next_addr_in;
   sst_pkg::req_type   req_ff, req_in;
   sst_pkg::rsp_type   res_ff, res_in;
   sst_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic                   entry_we;
   sst_pkg::sym_entry_type entry_wdata;
   logic [EW-1:0]          entry_rdata;
   sst_pkg::sym_entry_type ent_rd;
   logic                   scope_we;
   logic [LW-1:0]          scope_waddr;
   logic [LW-1:0]          scope_raddr;
   logic [CW-1:0]          scope_rdata;

   logic [LW-1:0]   level_up;
   logic [LW-1:0]   level_dn;
   logic [LW+3:0]   cur_wide;
   logic [LW+3:0]   up_wide;
   logic [LW+3:0]   dn_wide;
   logic [3:0]      lvl_cur4;
   logic [3:0]      lvl_up4;
   logic [3:0]      lvl_dn4;
   logic            accept;
   logic            hit;
   logic            miss;
   logic [CW-1:0]   lo_sel;

   assign level_up = level_ff + 1'b1;
   assign level_dn = level_ff - 1'b1;
   assign cur_wide = {4'b0000, level_ff};
   assign up_wide  = {4'b0000, level_up};
   assign dn_wide  = {4'b0000, level_dn};
   assign lvl_cur4 = cur_wide[3:0];
   assign lvl_up4  = up_wide[3:0];
   assign lvl_dn4  = dn_wide[3:0];

   assign ent_rd = sst_pkg::sym_entry_type'(entry_rdata);

   assign req_ready = (state_ff == sst_pkg::FSM_IDLE);
   assign accept    = req_valid && req_ready;
   assign hit       = pend_ff && !empty_ff && (ent_rd.name_id == req_ff.name_id);
   assign miss      = empty_ff || (pend_ff && last_ff && !hit);
   assign lo_sel    = (req_data.action == sst_pkg::ACT_INSERT) ? cur_start_ff : '0;

   assign scope_raddr = level_dn;
   assign scope_waddr = level_up;

   sst_ram #(
      .DEPTH (MAX_ENTRIES),
      .AW    (IW),
      .DW    (EW)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (entry_we),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (entry_wdata),
      .rd_addr (ptr_ff[IW-1:0]),
      .rd_data (entry_rdata)
   );

   sst_ram #(
      .DEPTH (MAX_LEVELS),
      .AW    (LW),
      .DW    (CW)
   ) u_scope_ram (
      .clock   (clock),
      .wr_en   (scope_we),
      .wr_addr (scope_waddr),
      .wr_data (count_ff),
      .rd_addr (scope_raddr),
      .rd_data (scope_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sst_pkg::FSM_IDLE;
         level_ff     <= '0;
         count_ff     <= '0;
         cur_start_ff <= '0;
         pend_ff      <= 1'b0;
         last_ff      <= 1'b0;
         empty_ff     <= 1'b0;
         step_ff      <= sst_pkg::ADDRESS_STEP_RESET;
         next_addr_ff <= sst_pkg::BASE_ADDRESS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         count_ff     <= count_in;
         cur_start_ff <= cur_start_in;
         pend_ff      <= pend_in;
         last_ff      <= last_in;
         empty_ff     <= empty_in;
         step_ff      <= step_in;
         next_addr_ff <= next_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff  <= lo_in;
      ptr_ff <= ptr_in;
      req_ff <= req_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      count_in     = count_ff;
      cur_start_in = cur_start_ff;
      lo_in        = lo_ff;
      ptr_in       = ptr_ff;
      pend_in      = pend_ff;
      last_in      = last_ff;
      empty_in     = empty_ff;
      step_in      = step_ff;
      next_addr_in = next_addr_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      entry_we     = 1'b0;
      scope_we     = 1'b0;
      entry_wdata  = '{name_id: req_ff.name_id, type_code: req_ff.type_code,
                       address: next_addr_ff, scope: lvl_cur4};

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         sst_pkg::FSM_IDLE: begin
            if (accept) begin
               req_in           = req_data;
               res_in           = '0;
               res_in.level_now = lvl_cur4;
               unique case (req_data.action)
                  sst_pkg::ACT_INSERT, sst_pkg::ACT_LOOKUP: begin
                     lo_in    = lo_sel;
                     empty_in = (count_ff == lo_sel);
                     ptr_in   = count_ff - 1'b1;
                     pend_in  = 1'b0;
                     last_in  = 1'b0;
                     state_in = sst_pkg::FSM_SCAN;
                  end
                  sst_pkg::ACT_ENTER: begin
                     if (level_ff == LW'(MAX_LEVELS - 1)) begin
                        res_in.status = sst_pkg::ST_DEEP;
                     end else begin
                        level_in         = level_up;
                        scope_we         = 1'b1;
                        cur_start_in     = count_ff;
                        res_in.level_now = lvl_up4;
                     end
                     state_in = sst_pkg::FSM_EMIT;
                  end
                  sst_pkg::ACT_LEAVE: begin
                     if (level_ff == '0) begin
                        res_in.status = sst_pkg::ST_UNDERFLOW;
                        state_in      = sst_pkg::FSM_EMIT;
                     end else begin
                        // drop the scope's entries; fetch the outer scope start
                        count_in         = cur_start_ff;
                        level_in         = level_dn;
                        res_in.level_now = lvl_dn4;
                        state_in         = sst_pkg::FSM_LEAVE_WAIT;
                     end
                  end
                  default: ;
               endcase
            end
         end

         sst_pkg::FSM_SCAN: begin
            if (hit) begin
               res_in.status        = (req_ff.action == sst_pkg::ACT_INSERT) ?
                                      sst_pkg::ST_REDECL : sst_pkg::ST_OK;
               res_in.found_type    = ent_rd.type_code;
               res_in.found_address = ent_rd.address;
               res_in.found_scope   = ent_rd.scope;
               state_in             = sst_pkg::FSM_EMIT;
            end else if (miss) begin
               if (req_ff.action == sst_pkg::ACT_LOOKUP) begin
                  res_in.status = sst_pkg::ST_UNDECL;
               end else if (count_ff == CW'(MAX_ENTRIES)) begin
                  res_in.status = sst_pkg::ST_FULL;
               end else begin
                  entry_we             = 1'b1;
                  count_in             = count_ff + 1'b1;
                  next_addr_in         = next_addr_ff + {16'd0, step_ff};
                  res_in.status        = sst_pkg::ST_OK;
                  res_in.found_type    = req_ff.type_code;
                  res_in.found_address = next_addr_ff;
                  res_in.found_scope   = lvl_cur4;
               end
               state_in = sst_pkg::FSM_EMIT;
            end else begin
               // issue the next older entry
               pend_in = 1'b1;
               last_in = (ptr_ff == lo_ff);
               ptr_in  = ptr_ff - 1'b1;
            end
         end

         sst_pkg::FSM_LEAVE_WAIT: begin
            cur_start_in = (level_ff == '0) ? '0 : scope_rdata;
            state_in     = sst_pkg::FSM_EMIT;
         end

         sst_pkg::FSM_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = sst_pkg::FSM_IDLE;
            end
         end

         default: state_in = sst_pkg::FSM_IDLE;
      endcase

      if (csr_we) begin
         if (csr_index == sst_pkg::CSR_BASE_ADDRESS) begin
            next_addr_in = csr_wdata;
         end else if (csr_index == sst_pkg::CSR_ADDRESS_STEP) begin
            step_in = csr_wdata[15:0];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count above table size");

   a_start_below_count: assert property (@(posedge clock) disable iff (reset)
      cur_start_ff <= count_ff)
      else $error("scope start beyond entry count");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LW'(MAX_LEVELS - 1))
      else $error("nesting level out of range");

   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      entry_we |-> (state_ff == sst_pkg::FSM_SCAN) && miss && !hit)
      else $error("entry write outside a missed insert search");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      entry_we |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not advance entry count");

endmodule

[hdl/sst_ram.sv]
module sst_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH),
   parameter int DW    = 60
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   localparam int ENTRY_SLOTS  = 64;
   localparam int SCOPE_LEVELS = 16;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 138;
   localparam int QUIET_PHASES = 2;

   // indexes above the two real registers; writes there must be dropped
   localparam logic [sst_pkg::CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [sst_pkg::CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   sst_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   sst_pkg::rsp_type rsp_data;
   logic             csr_we    = 1'b0;
   logic [sst_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]      csr_wdata = '0;

   scoped_symbol_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // shadow copy of the symbol table
   logic [15:0] sym_name  [ENTRY_SLOTS];
   logic [7:0]  sym_type  [ENTRY_SLOTS];
   logic [31:0] sym_addr  [ENTRY_SLOTS];
   logic [3:0]  sym_scope [ENTRY_SLOTS];
   int          scope_first [SCOPE_LEVELS];
   int          sym_count   = 0;
   int          cur_level   = 0;
   logic [31:0] addr_counter = sst_pkg::BASE_ADDRESS_RESET;
   logic [15:0] addr_step    = sst_pkg::ADDRESS_STEP_RESET;

   sst_pkg::req_type req_backlog[$];
   sst_pkg::rsp_type awaited_replies[$];
   logic [15:0]      name_pool [48];

   bit idle_on        = 1'b1;
   bit hold_for_drain = 1'b0;
   int send_gap       = 0;
   int rsp_stall      = 0;
   int errors         = 0;
   int requests_taken = 0;
   int replies_seen   = 0;
   int status_count [6];

   initial begin
      foreach (scope_first[i]) scope_first[i] = 0;
      foreach (status_count[i]) status_count[i] = 0;
   end

   function automatic int find_newest(int lo, logic [15:0] name);
      for (int i = sym_count - 1; i >= lo; i--)
         if (sym_name[i] == name) return i;
      return -1;
   endfunction

   function automatic sst_pkg::rsp_type with_entry(sst_pkg::rsp_type o, int i);
      o.found_type    = sym_type[i];
      o.found_address = sym_addr[i];
      o.found_scope   = sym_scope[i];
      return o;
   endfunction

   // Advance the shadow table by one request and return the reply it gives.
   function automatic sst_pkg::rsp_type apply_symbol_action(sst_pkg::req_type r);
      sst_pkg::rsp_type o;
      int               hit;
      o = '0;
      o.status = sst_pkg::ST_OK;
      case (r.action)
         sst_pkg::ACT_INSERT: begin
            hit = find_newest(scope_first[cur_level], r.name_id);
            if (hit >= 0) begin
               o.status = sst_pkg::ST_REDECL;
               o = with_entry(o, hit);
            end else if (sym_count >= ENTRY_SLOTS) begin
               o.status = sst_pkg::ST_FULL;
            end else begin
               sym_name[sym_count]  = r.name_id;
               sym_type[sym_count]  = r.type_code;
               sym_addr[sym_count]  = addr_counter;
               sym_scope[sym_count] = cur_level[3:0];
               o = with_entry(o, sym_count);
               sym_count++;
               addr_counter = addr_counter + {16'd0, addr_step};
            end
         end
         sst_pkg::ACT_LOOKUP: begin
            hit = find_newest(0, r.name_id);
            if (hit >= 0) o = with_entry(o, hit);
            else o.status = sst_pkg::ST_UNDECL;
         end
         sst_pkg::ACT_ENTER: begin
            if (cur_level + 1 >= SCOPE_LEVELS) begin
               o.status = sst_pkg::ST_DEEP;
            end else begin
               cur_level++;
               scope_first[cur_level] = sym_count;
            end
         end
         default: begin
            if (cur_level == 0) begin
               o.status = sst_pkg::ST_UNDERFLOW;
            end else begin
               sym_count = scope_first[cur_level];
               cur_level--;
            end
         end
      endcase
      o.level_now = cur_level[3:0];
      return o;
   endfunction

   always @(posedge clock) begin : request_driver
      logic             valid_next;
      sst_pkg::req_type data_next;
      valid_next = req_valid;
      data_next  = req_data;
      if (reset) begin
         valid_next = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_replies = {awaited_replies, apply_symbol_action(req_data)};
            requests_taken++;
            valid_next = 1'b0;
         end
         if (!valid_next) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (hold_for_drain) begin
               // stay quiet until every outstanding reply is back
               if (awaited_replies.size() == 0) hold_for_drain = 1'b0;
            end else if (req_backlog.size() != 0) begin
               if (idle_on && $urandom_range(0, 9) == 0) begin
                  send_gap = $urandom_range(0, 15);
               end else begin
                  valid_next     = 1'b1;
                  data_next      = req_backlog.pop_front();
                  hold_for_drain = idle_on && ($urandom_range(0, 99) == 0);
               end
            end
         end
      end
      req_valid <= valid_next;
      req_data  <= data_next;
   end

   task automatic check_field(string label, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", label, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : reply_monitor
      sst_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            replies_seen++;
            if (int'(rsp_data.status) < 6) status_count[int'(rsp_data.status)]++;
            if (awaited_replies.size() == 0) begin
               $error("reply with no request outstanding: status %0d", rsp_data.status);
               errors++;
            end else begin
               want = awaited_replies.pop_front();
               check_field("status", want.status, rsp_data.status);
               check_field("found_type", want.found_type, rsp_data.found_type);
               check_field("found_address", want.found_address, rsp_data.found_address);
               check_field("found_scope", want.found_scope, rsp_data.found_scope);
               check_field("level_now", want.level_now, rsp_data.level_now);
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_stall = $urandom_range(0, 15);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic queue_req(sst_pkg::action_type a, logic [15:0] name, logic [7:0] code);
      sst_pkg::req_type r;
      r.action    = a;
      r.name_id   = name;
      r.type_code = code;
      req_backlog = {req_backlog, r};
   endtask

   task automatic queue_random(int count, int w_ins, int w_look, int w_enter, int pool_size);
      sst_pkg::action_type a;
      int                  roll;
      logic [15:0]         name;
      for (int k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < w_ins) a = sst_pkg::ACT_INSERT;
         else if (roll < w_ins + w_look) a = sst_pkg::ACT_LOOKUP;
         else if (roll < w_ins + w_look + w_enter) a = sst_pkg::ACT_ENTER;
         else a = sst_pkg::ACT_LEAVE;
         if ($urandom_range(0, 15) == 0) name = 16'($urandom_range(0, 65535));
         else name = name_pool[$urandom_range(0, pool_size - 1)];
         queue_req(a, name, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic write_csr(logic [sst_pkg::CSR_INDEX_W-1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == sst_pkg::CSR_BASE_ADDRESS) begin
         addr_counter = value;
      end else if (idx == sst_pkg::CSR_ADDRESS_STEP) begin
         addr_step = value[15:0];
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (req_backlog.size() != 0 || req_valid || awaited_replies.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   initial begin : stimulus
      int pool_size;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty table, scope edges, shadowing
      queue_req(sst_pkg::ACT_LOOKUP, 16'h0000, 8'h00);
      queue_req(sst_pkg::ACT_LEAVE,  16'hFFFF, 8'hFF);
      queue_req(sst_pkg::ACT_INSERT, 16'h0000, 8'h00);
      queue_req(sst_pkg::ACT_INSERT, 16'hFFFF, 8'hFF);
      queue_req(sst_pkg::ACT_INSERT, 16'h0000, 8'h77);
      queue_req(sst_pkg::ACT_LOOKUP, 16'hFFFF, 8'h00);
      queue_req(sst_pkg::ACT_ENTER,  16'h1234, 8'hA5);
      queue_req(sst_pkg::ACT_INSERT, 16'h0000, 8'h5A);
      queue_req(sst_pkg::ACT_LOOKUP, 16'h0000, 8'h00);
      queue_req(sst_pkg::ACT_LOOKUP, 16'hFFFF, 8'h00);
      queue_req(sst_pkg::ACT_INSERT, 16'hFFFF, 8'h01);
      queue_req(sst_pkg::ACT_LOOKUP, 16'hABCD, 8'h00);
      queue_req(sst_pkg::ACT_LEAVE,  16'h0000, 8'h00);
      queue_req(sst_pkg::ACT_LOOKUP, 16'h0000, 8'h00);
      queue_req(sst_pkg::ACT_LEAVE,  16'h0000, 8'h00);
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         idle_on = (p < PHASES - QUIET_PHASES);
         case (p)
            0: begin
               write_csr(sst_pkg::CSR_BASE_ADDRESS, 32'h0000_0000);
               write_csr(sst_pkg::CSR_ADDRESS_STEP, 32'h0000_0000);
            end
            1: begin
               write_csr(sst_pkg::CSR_BASE_ADDRESS, 32'hFFFF_FFFF);
               write_csr(sst_pkg::CSR_ADDRESS_STEP, 32'hFFFF_FFFF);
            end
            2: begin
               write_csr(sst_pkg::CSR_BASE_ADDRESS, 32'hFFFF_FFF0);
               write_csr(sst_pkg::CSR_ADDRESS_STEP, 32'h0000_0001);
            end
            3: begin
               write_csr(CSR_SPARE_2, $urandom);
               write_csr(CSR_SPARE_3, $urandom);
            end
            default: begin
               write_csr(sst_pkg::CSR_BASE_ADDRESS, $urandom);
               // upper bits of the step write are don't-care
               write_csr(sst_pkg::CSR_ADDRESS_STEP,
                         {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))});
            end
         endcase
         foreach (name_pool[i]) name_pool[i] = 16'($urandom_range(0, 65535));
         pool_size = (p == 4) ? 48 : $urandom_range(4, 48);
         case (p % 3)
            0: queue_random(PHASE_ITEMS, 55, 20, 15, pool_size);
            1: queue_random(PHASE_ITEMS, 20, 20, 45, pool_size);
            default: queue_random(PHASE_ITEMS, 25, 35, 10, pool_size);
         endcase
         if (p == 4) queue_random(PHASE_ITEMS, 80, 10, 10, pool_size);
         wait_idle();
      end

      repeat (100) @(posedge clock);
      $display("%0d requests, %0d replies over %0d register settings", requests_taken,
               replies_seen, PHASES);
      $display("ok %0d, redeclared %0d, undeclared %0d, full %0d, too deep %0d, underflow %0d",
               status_count[0], status_count[1], status_count[2], status_count[3],
               status_count[4], status_count[5]);
      if (errors == 0 && awaited_replies.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : watchdog
      #4ms;
      $display("timeout with %0d replies outstanding", awaited_replies.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
